// ===== hdl/swad_pkg.sv =====
`default_nettype none

package swad_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned LevelWidth = 10;
  localparam int unsigned WheelWidth = 11;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CountWidth-1:0] LongTicksReset = CountWidth'(100);
  localparam logic [LevelWidth-1:0] PressLevelReset = LevelWidth'(650);
  localparam logic [LevelWidth-1:0] FullLevelReset = LevelWidth'(660);

  typedef enum logic [2:0] {
    ActKeep         = 3'd0,
    ActDownToMiddle = 3'd1,
    ActMiddleToUp   = 3'd2,
    ActUpToMiddle   = 3'd3,
    ActMiddleToDown = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CfgLongPressTicks = 2'd0,
    CfgPressLevel     = 2'd1,
    CfgFullLevel      = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic up_short;
    logic up_long;
    logic up_toggle;
    logic down_short;
    logic down_long;
    logic down_toggle;
  } gesture_t;

endpackage

`default_nettype wire

// ===== hdl/swad_switch.sv =====
`default_nettype none

module swad_switch import swad_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    advance_i,
  input  wire logic [1:0] pos_i,
  output action_e      action_o
);

  logic [1:0] prev_q;
  action_e    held_q;
  logic signed [2:0] diff;

  assign diff = $signed({1'b0, pos_i}) - $signed({1'b0, prev_q});

  always_comb begin
    unique case (diff)
      3'sd0:   action_o = ActKeep;
      3'sd1:   action_o = ActDownToMiddle;
      -3'sd2:  action_o = ActMiddleToUp;
      3'sd2:   action_o = ActUpToMiddle;
      -3'sd1:  action_o = ActMiddleToDown;
      default: action_o = held_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 2'd0;
      held_q <= ActKeep;
    end else if (advance_i) begin
      prev_q <= pos_i;
      held_q <= action_o;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swad_wheel.sv =====
`default_nettype none

module swad_wheel import swad_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         advance_i,
  input  wire logic signed [WheelWidth-1:0] wheel_i,
  input  wire logic [CountWidth-1:0]        long_ticks_i,
  input  wire logic [LevelWidth-1:0]        press_level_i,
  input  wire logic [LevelWidth-1:0]        full_level_i,
  output gesture_t                          gesture_o
);

  logic up_pend_q, up_pend_d, dn_pend_q, dn_pend_d;
  logic up_tog_q, up_tog_d, dn_tog_q, dn_tog_d;
  logic up_long_q, up_long_d, dn_long_q, dn_long_d;
  logic up_prev_q, dn_prev_q;
  logic [CountWidth-1:0] up_cnt_q, up_cnt_d, dn_cnt_q, dn_cnt_d;

  logic signed [WheelWidth:0] w, pl, fl;
  logic is_zero, up_press, dn_press, up_arm, dn_arm;
  logic up_short, dn_short, dn_hit, up_hit;

  assign w  = WheelWidth'(wheel_i) == '0 ? '0 : {wheel_i[WheelWidth-1], wheel_i};
  assign pl = $signed({2'b00, press_level_i});
  assign fl = $signed({2'b00, full_level_i});

  assign is_zero  = (wheel_i == '0);
  assign up_arm   = (w == fl);
  assign dn_arm   = !up_arm && (w == -fl);
  assign up_press = (w >= pl);
  assign dn_press = (w <= -pl);

  always_comb begin
    up_pend_d = up_pend_q | up_arm;
    dn_pend_d = dn_pend_q | dn_arm;
    up_tog_d  = up_tog_q;
    dn_tog_d  = dn_tog_q;
    up_long_d = up_long_q;
    dn_long_d = dn_long_q;

    if (is_zero) begin
      dn_tog_d  = dn_tog_q ^ dn_pend_d;
      up_tog_d  = up_tog_q ^ up_pend_d;
      dn_pend_d = 1'b0;
      up_pend_d = 1'b0;
    end

    up_cnt_d = up_press ? up_cnt_q + CountWidth'(1) : '0;
    dn_cnt_d = dn_press ? dn_cnt_q + CountWidth'(1) : '0;
    up_short = up_press && !up_prev_q;
    dn_short = dn_press && !dn_prev_q;

    dn_hit = (dn_cnt_d >= long_ticks_i);
    up_hit = !dn_hit && (up_cnt_d >= long_ticks_i);

    if (dn_hit) begin
      dn_cnt_d  = long_ticks_i;
      dn_long_d = 1'b1;
      dn_pend_d = 1'b0;
      dn_tog_d  = 1'b0;
      dn_short  = 1'b0;
    end
    if (up_hit) begin
      up_cnt_d  = long_ticks_i;
      up_long_d = 1'b1;
      up_pend_d = 1'b0;
      up_tog_d  = 1'b0;
      up_short  = 1'b0;
    end

    if (is_zero) begin
      dn_cnt_d  = '0;
      up_cnt_d  = '0;
      dn_long_d = 1'b0;
      up_long_d = 1'b0;
    end
  end

  assign gesture_o = '{
    up_short:    up_short,
    up_long:     up_long_d,
    up_toggle:   up_tog_d,
    down_short:  dn_short,
    down_long:   dn_long_d,
    down_toggle: dn_tog_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_pend_q <= 1'b0;
      dn_pend_q <= 1'b0;
      up_tog_q  <= 1'b0;
      dn_tog_q  <= 1'b0;
      up_long_q <= 1'b0;
      dn_long_q <= 1'b0;
      up_prev_q <= 1'b0;
      dn_prev_q <= 1'b0;
      up_cnt_q  <= '0;
      dn_cnt_q  <= '0;
    end else if (advance_i) begin
      up_pend_q <= up_pend_d;
      dn_pend_q <= dn_pend_d;
      up_tog_q  <= up_tog_d;
      dn_tog_q  <= dn_tog_d;
      up_long_q <= up_long_d;
      dn_long_q <= dn_long_d;
      up_prev_q <= up_press;
      dn_prev_q <= dn_press;
      up_cnt_q  <= up_cnt_d;
      dn_cnt_q  <= dn_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/switch_wheel_action_detector.sv =====
// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | tdata 16b: left_switch, right_switch, wheel
// m_axis    | out | m_axis_tvalid/tready    | tdata 16b: actions and wheel flags
// cfg       | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle sustained while m_axis is ready; items pass through the input register, then the result register
// the per-item state update runs when an item moves from the input register to the
// result register, in the same cycle
// a stall on m_axis backs up through both registers, one bubble-free stage each
// reset clears all gesture and switch state and loads the register defaults
// cfg is always ready and takes effect on the next cycle

`default_nettype none

module switch_wheel_action_detector import swad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] left_switch, [3:2] right_switch, [14:4] wheel, [15] zero
  input  wire logic [15:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] left_action, [5:3] right_action, [6] up_short, [7] up_long,
  // [8] up_toggle, [9] down_short, [10] down_long, [11] down_toggle, [15:12] zero
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i
);

  logic [CountWidth-1:0] long_ticks_q;
  logic [LevelWidth-1:0] press_level_q, full_level_q;

  logic        in_valid_q, out_valid_q;
  logic [1:0]  left_q, right_q;
  logic signed [WheelWidth-1:0] wheel_q;
  logic [15:0] out_data_q;

  logic     out_ready, advance;
  action_e  left_act, right_act;
  gesture_t gesture;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q  <= LongTicksReset;
      press_level_q <= PressLevelReset;
      full_level_q  <= FullLevelReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLongPressTicks: long_ticks_q  <= CountWidth'(cfg_data_i);
        CfgPressLevel:     press_level_q <= cfg_data_i[LevelWidth-1:0];
        CfgFullLevel:      full_level_q  <= cfg_data_i[LevelWidth-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (out_ready) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      left_q  <= s_axis_tdata[1:0];
      right_q <= s_axis_tdata[3:2];
      wheel_q <= s_axis_tdata[14:4];
    end
    if (advance) begin
      out_data_q <= {4'b0000, gesture.down_toggle, gesture.down_long, gesture.down_short,
                     gesture.up_toggle, gesture.up_long, gesture.up_short,
                     right_act, left_act};
    end
  end

  swad_switch u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .pos_i     (left_q),
    .action_o  (left_act)
  );

  swad_switch u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .pos_i     (right_q),
    .action_o  (right_act)
  );

  swad_wheel u_wheel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .wheel_i       (wheel_q),
    .long_ticks_i  (long_ticks_q),
    .press_level_i (press_level_q),
    .full_level_i  (full_level_q),
    .gesture_o     (gesture)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
